// ===== src/ptc_pkg.sv =====
package ptc_pkg;

  localparam int RAW_W     = 24;
  localparam int COEF_W    = 16;
  localparam int DT_W      = 25;
  localparam int PROD_W    = 42;
  localparam int DTSQ_W    = 48;
  localparam int Q_W       = 19;
  localparam int TI_W      = 17;
  localparam int QSQ_W     = 34;
  localparam int OFF_W     = 38;
  localparam int SENS_W    = 37;
  localparam int TEMP_W    = 20;
  localparam int OUT_W     = 32;
  localparam int IDX_W     = 3;

  localparam logic signed [TEMP_W-1:0] TEMP_REF = 20'sd2000;

  // register indexes
  localparam logic [IDX_W-1:0] REG_SENS      = 3'd0;
  localparam logic [IDX_W-1:0] REG_OFFSET    = 3'd1;
  localparam logic [IDX_W-1:0] REG_SENS_TC   = 3'd2;
  localparam logic [IDX_W-1:0] REG_OFFSET_TC = 3'd3;
  localparam logic [IDX_W-1:0] REG_TREF      = 3'd4;
  localparam logic [IDX_W-1:0] REG_TSENS     = 3'd5;

  typedef struct packed {
    logic [COEF_W-1:0] sens;
    logic [COEF_W-1:0] offset;
    logic [COEF_W-1:0] sens_tc;
    logic [COEF_W-1:0] offset_tc;
    logic [COEF_W-1:0] tref;
    logic [COEF_W-1:0] tsens;
  } coef_t;

  typedef struct packed {
    logic [RAW_W-1:0] d1;
    logic [RAW_W-1:0] d2;
  } raw_t;

  // first-order results
  typedef struct packed {
    logic [RAW_W-1:0]         d1;
    logic signed [Q_W-1:0]    q;
    logic [TI_W-1:0]          ti;
    logic                     low;
    logic signed [OFF_W-1:0]  off;
    logic signed [SENS_W-1:0] sens;
  } tc_t;

  // corrected terms
  typedef struct packed {
    logic [RAW_W-1:0]         d1;
    logic signed [TEMP_W-1:0] temp;
    logic                     low;
    logic signed [OFF_W-1:0]  off2;
    logic signed [SENS_W-1:0] sens2;
  } cp_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] temp;
    logic signed [OUT_W-1:0] press;
    logic                    low;
  } res_t;

endpackage

// ===== src/ptc_temp.sv =====
module ptc_temp (
  input  logic           clk,
  input  logic           rst,
  input  ptc_pkg::coef_t coef,
  input  logic           in_valid,
  output logic           in_ready,
  input  ptc_pkg::raw_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output ptc_pkg::tc_t   out_data
);

  logic v1, v2, v3;
  logic r1, r2, r3;

  logic [ptc_pkg::RAW_W-1:0]          s1_d1;
  logic signed [ptc_pkg::DT_W-1:0]    s1_dt;
  logic [ptc_pkg::RAW_W-1:0]          s2_d1;
  logic signed [ptc_pkg::PROD_W-1:0]  s2_p6, s2_p4, s2_p3;
  logic [ptc_pkg::DTSQ_W-1:0]         s2_dtsq;

  logic signed [ptc_pkg::DT_W-1:0]     dt_next;
  logic signed [ptc_pkg::COEF_W:0]     c6s, c4s, c3s;
  logic signed [2*ptc_pkg::DT_W-1:0]   dtsq_full;
  logic signed [ptc_pkg::PROD_W-1:0]   p6_b, p4_b, p3_b;
  logic [51:0]                         ti_x11;
  logic signed [ptc_pkg::OFF_W-1:0]    off_next;
  logic signed [ptc_pkg::SENS_W-1:0]   sens_next;

  assign r3       = !v3 || out_ready;
  assign r2       = !v2 || r3;
  assign r1       = !v1 || r2;
  assign in_ready = r1;
  assign out_valid = v3;

  // stage 1: dT
  assign dt_next = $signed({1'b0, in_data.d2}) - $signed({1'b0, coef.tref, 8'd0});

  // stage 2: products
  assign c6s       = $signed({1'b0, coef.tsens});
  assign c4s       = $signed({1'b0, coef.offset_tc});
  assign c3s       = $signed({1'b0, coef.sens_tc});
  assign dtsq_full = s1_dt * s1_dt;

  // stage 3: truncating shifts, OFF, SENS, Ti
  assign p6_b = s2_p6 + $signed({19'd0, {23{s2_p6[ptc_pkg::PROD_W-1]}}});
  assign p4_b = s2_p4 + $signed({36'd0, {6{s2_p4[ptc_pkg::PROD_W-1]}}});
  assign p3_b = s2_p3 + $signed({35'd0, {7{s2_p3[ptc_pkg::PROD_W-1]}}});

  assign off_next  = $signed({5'd0, coef.offset, 17'd0})
                   + $signed({{2{p4_b[41]}}, p4_b[41:6]});
  assign sens_next = $signed({5'd0, coef.sens, 16'd0})
                   + $signed({{2{p3_b[41]}}, p3_b[41:7]});
  assign ti_x11    = ({4'd0, s2_dtsq} << 3) + ({4'd0, s2_dtsq} << 1) + {4'd0, s2_dtsq};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
    end
    if (r1 && in_valid) begin
      s1_d1 <= in_data.d1;
      s1_dt <= dt_next;
    end
    if (r2 && v1) begin
      s2_d1   <= s1_d1;
      s2_p6   <= c6s * s1_dt;
      s2_p4   <= c4s * s1_dt;
      s2_p3   <= c3s * s1_dt;
      s2_dtsq <= dtsq_full[ptc_pkg::DTSQ_W-1:0];
    end
    if (r3 && v2) begin
      out_data.d1   <= s2_d1;
      out_data.q    <= p6_b[41:23];
      out_data.low  <= p6_b[41];
      out_data.ti   <= ti_x11[51:35];
      out_data.off  <= off_next;
      out_data.sens <= sens_next;
    end
  end

endmodule

// ===== src/ptc_corr.sv =====
module ptc_corr (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  ptc_pkg::tc_t in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output ptc_pkg::cp_t out_data
);

  logic v4, v5;
  logic r4, r5;

  ptc_pkg::tc_t              s4;
  logic [ptc_pkg::QSQ_W-1:0] s4_qsq;

  logic signed [2*ptc_pkg::Q_W-1:0]    qsq_full;
  logic [38:0]                         offi_x31;
  logic [39:0]                         sensi_x63;
  logic [35:0]                         offi;
  logic [34:0]                         sensi;
  logic signed [ptc_pkg::TEMP_W-1:0]   temp_next;
  logic signed [ptc_pkg::OFF_W-1:0]    off2_next;
  logic signed [ptc_pkg::SENS_W-1:0]   sens2_next;

  assign r5        = !v5 || out_ready;
  assign r4        = !v4 || r5;
  assign in_ready  = r4;
  assign out_valid = v5;

  assign qsq_full = in_data.q * in_data.q;

  assign offi_x31  = ({5'd0, s4_qsq} << 5) - {5'd0, s4_qsq};
  assign sensi_x63 = ({6'd0, s4_qsq} << 6) - {6'd0, s4_qsq};
  assign offi      = s4.low ? offi_x31[38:3] : 36'd0;
  assign sensi     = s4.low ? sensi_x63[39:5] : 35'd0;

  assign temp_next  = ptc_pkg::TEMP_REF + $signed({s4.q[18], s4.q})
                    - $signed({3'd0, (s4.low ? s4.ti : 17'd0)});
  assign off2_next  = s4.off - $signed({2'd0, offi});
  assign sens2_next = s4.sens - $signed({2'd0, sensi});

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (r4) v4 <= in_valid;
      if (r5) v5 <= v4;
    end
    if (r4 && in_valid) begin
      s4     <= in_data;
      s4_qsq <= qsq_full[ptc_pkg::QSQ_W-1:0];
    end
    if (r5 && v4) begin
      out_data.d1    <= s4.d1;
      out_data.temp  <= temp_next;
      out_data.low   <= s4.low;
      out_data.off2  <= off2_next;
      out_data.sens2 <= sens2_next;
    end
  end

endmodule

// ===== src/ptc_press.sv =====
module ptc_press (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  ptc_pkg::cp_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output ptc_pkg::res_t out_data
);

  logic v6, v7, v8, v9, v10;
  logic r6, r7, r8, r9, r10;

  logic signed [ptc_pkg::TEMP_W-1:0] s6_temp, s7_temp, s8_temp, s9_temp;
  logic                              s6_low, s7_low, s8_low, s9_low;
  logic signed [ptc_pkg::OFF_W-1:0]  s6_off2, s7_off2, s8_off2;
  logic [41:0]                       s6_plo;
  logic signed [43:0]                s6_phi;
  logic signed [61:0]                s7_prod;
  logic signed [40:0]                s8_a;
  logic signed [41:0]                s9_b;

  logic signed [61:0] prod_next;
  logic signed [61:0] prod_b;
  logic signed [41:0] b_next;
  logic signed [41:0] b_b;

  assign r10       = !v10 || out_ready;
  assign r9        = !v9 || r10;
  assign r8        = !v8 || r9;
  assign r7        = !v7 || r8;
  assign r6        = !v6 || r7;
  assign in_ready  = r6;
  assign out_valid = v10;

  // D1*SENS2 as two partial products, joined in the next stage
  assign prod_next = $signed({s6_phi, 18'd0}) + $signed({20'd0, s6_plo});
  assign prod_b    = s7_prod + $signed({41'd0, {21{s7_prod[61]}}});
  assign b_next    = $signed({s8_a[40], s8_a}) - $signed({{4{s8_off2[37]}}, s8_off2});
  assign b_b       = s9_b + $signed({27'd0, {15{s9_b[41]}}});

  always_ff @(posedge clk) begin
    if (rst) begin
      v6  <= 1'b0;
      v7  <= 1'b0;
      v8  <= 1'b0;
      v9  <= 1'b0;
      v10 <= 1'b0;
    end else begin
      if (r6)  v6  <= in_valid;
      if (r7)  v7  <= v6;
      if (r8)  v8  <= v7;
      if (r9)  v9  <= v8;
      if (r10) v10 <= v9;
    end
    if (r6 && in_valid) begin
      s6_temp <= in_data.temp;
      s6_low  <= in_data.low;
      s6_off2 <= in_data.off2;
      s6_plo  <= {18'd0, in_data.d1} * {24'd0, in_data.sens2[17:0]};
      s6_phi  <= $signed({1'b0, in_data.d1}) * $signed(in_data.sens2[36:18]);
    end
    if (r7 && v6) begin
      s7_temp <= s6_temp;
      s7_low  <= s6_low;
      s7_off2 <= s6_off2;
      s7_prod <= prod_next;
    end
    if (r8 && v7) begin
      s8_temp <= s7_temp;
      s8_low  <= s7_low;
      s8_off2 <= s7_off2;
      s8_a    <= prod_b[61:21];
    end
    if (r9 && v8) begin
      s9_temp <= s8_temp;
      s9_low  <= s8_low;
      s9_b    <= b_next;
    end
    // both results stay well inside 32 bits, so the clamp reduces to sign extension
    if (r10 && v9) begin
      out_data.temp  <= $signed({{12{s9_temp[19]}}, s9_temp});
      out_data.press <= $signed({{5{b_b[41]}}, b_b[41:15]});
      out_data.low   <= s9_low;
    end
  end

endmodule

// ===== src/pressure_temp_compensation.sv =====
// channel  | dir | signals                        | content
// s        | in  | s_tvalid s_tready s_tdata[47:0] | raw_pressure, raw_temperature
// m        | out | m_tvalid m_tready m_tdata[63:0] | temperature_centi_c, pressure_pa
//          |     | m_tuser[0]                      | low_temp_mode
// cfg      | in  | wr_en wr_index[2:0] wr_data     | calibration words, index 0..5
//
// One item per cycle sustained while m_tready stays high; each item passes ten register
// stages. The edge that takes an item loads the first one, and m_tvalid rises once the
// item reaches the last one.
// The multiplier stages hold the dT products, (TEMP-2000)^2 and D1*SENS2.
// Each stage holds while the next one is full and stalled; bubbles close up.
// rst clears all valid bits and the calibration words.
module pressure_temp_compensation (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // raw_pressure, raw_temperature
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // temperature_centi_c, pressure_pa
  output logic [0:0]  m_tuser,   // low_temp_mode
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [15:0] wr_data
);

  ptc_pkg::coef_t coef;
  ptc_pkg::raw_t  raw;
  ptc_pkg::tc_t   tc;
  ptc_pkg::cp_t   cp;
  ptc_pkg::res_t  res;
  logic           tc_valid, tc_ready;
  logic           cp_valid, cp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '0;
    end else if (wr_en) begin
      case (wr_index)
        ptc_pkg::REG_SENS:      coef.sens      <= wr_data;
        ptc_pkg::REG_OFFSET:    coef.offset    <= wr_data;
        ptc_pkg::REG_SENS_TC:   coef.sens_tc   <= wr_data;
        ptc_pkg::REG_OFFSET_TC: coef.offset_tc <= wr_data;
        ptc_pkg::REG_TREF:      coef.tref      <= wr_data;
        ptc_pkg::REG_TSENS:     coef.tsens     <= wr_data;
        default: ;
      endcase
    end
  end

  assign raw.d1 = s_tdata[23:0];
  assign raw.d2 = s_tdata[47:24];

  ptc_temp u_temp (
    .clk       (clk),
    .rst       (rst),
    .coef      (coef),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (raw),
    .out_valid (tc_valid),
    .out_ready (tc_ready),
    .out_data  (tc)
  );

  ptc_corr u_corr (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (tc_valid),
    .in_ready  (tc_ready),
    .in_data   (tc),
    .out_valid (cp_valid),
    .out_ready (cp_ready),
    .out_data  (cp)
  );

  ptc_press u_press (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cp_valid),
    .in_ready  (cp_ready),
    .in_data   (cp),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (res)
  );

  assign m_tdata = {res.press, res.temp};
  assign m_tuser = res.low;

endmodule

// ===== src/ptc_check.sv =====
module ptc_check (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic [0:0]  m_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_low_cold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> $signed(m_tdata[31:0]) < 32'sd2000)
    else $error("low-temperature flag with warm result");

  a_warm: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> $signed(m_tdata[31:0]) >= 32'sd2000)
    else $error("cold result without low-temperature flag");

  a_press_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[63:58] == 6'h00 || m_tdata[63:58] == 6'h3F)
    else $error("pressure beyond its reachable range");

endmodule

bind pressure_temp_compensation ptc_check u_check (.*);

// ===== verif/pressure_temp_compensation_tb.sv =====
module pressure_temp_compensation_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint SAT_MAX = 64'sd2147483647;
  localparam longint SAT_MIN = -64'sd2147483648;
  localparam longint T_REF = 2000;
  localparam longint MUL_TI = 11;
  localparam longint MUL_OFFI = 31;
  localparam longint MUL_SENSI = 63;
  localparam int NUM_REGS = 6;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT = 500000;
  localparam logic [ptc_pkg::IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [ptc_pkg::IDX_W-1:0] REG_SPARE_B = 3'd7;

  typedef logic [NUM_REGS-1:0][ptc_pkg::COEF_W-1:0] cal_set_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [47:0] s_tdata = '0;   // raw_pressure, raw_temperature
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [63:0] m_tdata;        // temperature_centi_c, pressure_pa
  logic [0:0] m_tuser;         // low_temp_mode
  logic wr_en = 1'b0;
  logic [ptc_pkg::IDX_W-1:0] wr_index = '0;
  logic [ptc_pkg::COEF_W-1:0] wr_data = '0;

  cal_set_t cal = '0;
  ptc_pkg::res_t due_readings[$];
  ptc_pkg::res_t want;
  ptc_pkg::res_t got;
  int errors = 0;
  int cycles = 0;
  int stall_left = 0;
  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;

  pressure_temp_compensation uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // signed division by 2^k, truncating toward zero
  function automatic longint trunc_div(input longint v, input int k);
    return v / (longint'(1) << k);
  endfunction

  function automatic logic signed [ptc_pkg::OUT_W-1:0] clamp32(input longint v);
    if (v > SAT_MAX) return ptc_pkg::OUT_W'(SAT_MAX);
    if (v < SAT_MIN) return ptc_pkg::OUT_W'(SAT_MIN);
    return ptc_pkg::OUT_W'(v);
  endfunction

  function automatic ptc_pkg::res_t compensate(input cal_set_t c,
                                               input logic [ptc_pkg::RAW_W-1:0] d1,
                                               input logic [ptc_pkg::RAW_W-1:0] d2);
    longint dt, temp, off, sens, ti, offi, sensi, dtemp, p;
    ptc_pkg::res_t r;
    dt = longint'(d2) - longint'(c[ptc_pkg::REG_TREF]) * 256;
    temp = T_REF + trunc_div(dt * longint'(c[ptc_pkg::REG_TSENS]), 23);
    off = longint'(c[ptc_pkg::REG_OFFSET]) * (longint'(1) << 17)
        + trunc_div(longint'(c[ptc_pkg::REG_OFFSET_TC]) * dt, 6);
    sens = longint'(c[ptc_pkg::REG_SENS]) * (longint'(1) << 16)
         + trunc_div(longint'(c[ptc_pkg::REG_SENS_TC]) * dt, 7);
    ti = 0;
    offi = 0;
    sensi = 0;
    r.low = (temp < T_REF);
    if (r.low) begin
      dtemp = temp - T_REF;
      ti = trunc_div(MUL_TI * dt * dt, 35);
      offi = trunc_div(MUL_OFFI * dtemp * dtemp, 3);
      sensi = trunc_div(MUL_SENSI * dtemp * dtemp, 5);
    end
    p = trunc_div(trunc_div(longint'(d1) * (sens - sensi), 21) - (off - offi), 15);
    r.temp = clamp32(temp - ti);
    r.press = clamp32(p);
    return r;
  endfunction

  // result side: random stall bursts
  always @(posedge clk) begin
    if (recv_idle && stall_left == 0 && $urandom_range(0, 7) == 0)
      stall_left = $urandom_range(1, 12);
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got.temp = m_tdata[31:0];
      got.press = m_tdata[63:32];
      got.low = m_tuser[0];
      if (due_readings.size() == 0) begin
        $error("unexpected result: temperature_centi_c %0d pressure_pa %0d",
               got.temp, got.press);
        errors++;
      end else begin
        want = due_readings.pop_front();
        if (got.temp !== want.temp) begin
          $error("temperature_centi_c: expected %0d, actual %0d", want.temp, got.temp);
          errors++;
        end
        if (got.press !== want.press) begin
          $error("pressure_pa: expected %0d, actual %0d", want.press, got.press);
          errors++;
        end
        if (got.low !== want.low) begin
          $error("low_temp_mode: expected %0b, actual %0b", want.low, got.low);
          errors++;
        end
      end
    end
  end

  task automatic send_conversion(input logic [ptc_pkg::RAW_W-1:0] d1,
                                 input logic [ptc_pkg::RAW_W-1:0] d2);
    if (send_idle && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {d2, d1};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    due_readings.push_back(compensate(cal, d1, d2));
  endtask

  task automatic wait_results;
    s_tvalid <= 1'b0;
    while (due_readings.size() != 0) @(posedge clk);
  endtask

  task automatic quiesce;
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // block must be idle; spare indexes must leave the calibration alone
  task automatic load_cal(input cal_set_t next, input logic [NUM_REGS-1:0] sel,
                          input bit spare);
    for (int i = 0; i < NUM_REGS; i++) begin
      if (sel[i]) begin
        wr_en <= 1'b1;
        wr_index <= ptc_pkg::IDX_W'(i);
        wr_data <= next[i];
        @(posedge clk);
        cal[i] = next[i];
      end
    end
    if (spare) begin
      wr_en <= 1'b1;
      wr_index <= REG_SPARE_A;
      wr_data <= ptc_pkg::COEF_W'($urandom);
      @(posedge clk);
      wr_index <= REG_SPARE_B;
      wr_data <= ptc_pkg::COEF_W'($urandom);
      @(posedge clk);
    end
    wr_en <= 1'b0;
  endtask

  function automatic cal_set_t typical_cal;
    cal_set_t c;
    c[ptc_pkg::REG_SENS] = 16'd34982;
    c[ptc_pkg::REG_OFFSET] = 16'd36352;
    c[ptc_pkg::REG_SENS_TC] = 16'd20328;
    c[ptc_pkg::REG_OFFSET_TC] = 16'd22354;
    c[ptc_pkg::REG_TREF] = 16'd26646;
    c[ptc_pkg::REG_TSENS] = 16'd26146;
    return c;
  endfunction

  function automatic logic [ptc_pkg::COEF_W-1:0] random_word;
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return ptc_pkg::COEF_W'($urandom);
    endcase
  endfunction

  function automatic logic [ptc_pkg::RAW_W-1:0] random_pressure;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return ptc_pkg::RAW_W'($urandom);
    endcase
  endfunction

  // mostly near the reference temperature so both sides of 20 C are hit
  function automatic logic [ptc_pkg::RAW_W-1:0] random_temperature(input cal_set_t c);
    longint v;
    case ($urandom_range(0, 5))
      0: return ptc_pkg::RAW_W'($urandom);
      1: return $urandom_range(0, 1) ? '0 : '1;
      default: begin
        v = longint'(c[ptc_pkg::REG_TREF]) * 256
          + longint'($urandom_range(0, 1 << 21)) - (1 << 20);
        if (v < 0) v = 0;
        if (v > 64'sd16777215) v = 64'sd16777215;
        return ptc_pkg::RAW_W'(v);
      end
    endcase
  endfunction

  task automatic test_reset_cal;
    send_conversion('0, '0);
    send_conversion('1, '1);
    send_conversion('1, '0);
    send_conversion('0, '1);
    quiesce();
  endtask

  task automatic test_full_scale;
    load_cal('1, '1, 1'b1);
    send_conversion('0, '0);
    send_conversion('1, '1);
    send_conversion('1, '0);
    send_conversion('0, '1);
    send_conversion(24'hAAAAAA, 24'h555555);
    send_conversion(24'h555555, 24'hAAAAAA);
    quiesce();
  endtask

  // tref*256 = 2^23 and tsens = 1: raw temperature 0 gives a first-order 19.99 C, 1 gives 20.00 C
  task automatic test_cold_threshold;
    cal_set_t c;
    c = typical_cal();
    c[ptc_pkg::REG_TREF] = 16'h8000;
    c[ptc_pkg::REG_TSENS] = 16'd1;
    load_cal(c, '1, 1'b1);
    send_conversion('1, 24'd0);
    send_conversion('1, 24'd1);
    send_conversion(24'h800000, 24'h7FFFFF);
    quiesce();
  endtask

  task automatic test_typical;
    load_cal(typical_cal(), '1, 1'b0);
    send_conversion(24'd4958179, 24'd6815414);
    send_conversion(24'd4958179, 24'd5000000);
    send_conversion(24'd4958179, 24'd9000000);
    quiesce();
  endtask

  task automatic test_random_cal;
    cal_set_t next;
    for (int ph = 0; ph < 8; ph++) begin
      send_idle = (ph % 3 != 2) && ph < 7;
      recv_idle = (ph % 4 != 3) && ph < 7;
      for (int i = 0; i < NUM_REGS; i++) next[i] = random_word();
      if (ph == 1) next = typical_cal();
      load_cal(next, (ph < 2) ? '1 : NUM_REGS'($urandom_range(1, 63)),
               1'($urandom_range(0, 1)));
      for (int n = 0; n < 180; n++) begin
        if (n == 90 && ph % 2 == 0) wait_results();
        send_conversion(random_pressure(), random_temperature(cal));
      end
      quiesce();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    cal = '0;
    @(posedge clk);
    test_reset_cal();
    test_full_scale();
    test_cold_threshold();
    test_typical();
    test_random_cal();
    quiesce();
    if (errors == 0 && due_readings.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
